>>> src/smk_pkg.sv
// shared types, constants and tables of the swerve module kinematics unit
package smk_pkg;

	// angle iteration count, clamped to the supported range
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ITERS = (ANGLE_ITERATIONS < 1) ? 1 :
		((ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS);

	// square root steps: two bits of a 38 bit sum of squares per step
	localparam int SQ_STEPS = 19;
	localparam int WHEEL_STEPS = (ITERS > SQ_STEPS) ? ITERS : SQ_STEPS;
	localparam int WHEEL_LAT = WHEEL_STEPS + 3;

	// quotient bits of the speed scaling divide
	localparam int DIV_STEPS = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
	localparam logic [1:0] REG_TRACK_WIDTH = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;
	localparam logic [1:0] REG_DEADBAND = 2'd3;

	localparam logic [12:0] WHEEL_BASE_RST = 13'd614;
	localparam logic [12:0] TRACK_WIDTH_RST = 13'd614;
	localparam logic [14:0] MAX_SPEED_RST = 15'd4096;
	localparam logic [14:0] DEADBAND_RST = 15'd51;

	// arctangent of 2^-i, 2^32 units per turn
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	// inverse cordic gain in Q2.30
	localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;

	// chassis command item
	typedef struct packed {
		logic signed [15:0] x_speed;
		logic signed [15:0] y_speed;
		logic signed [15:0] yaw_rate;
		logic [15:0] heading;
		logic field_relative;
	} cmd_t;

	// wheel command item
	typedef struct packed {
		logic stopped;
		logic signed [15:0] fl_angle;
		logic [15:0] fl_speed;
		logic signed [15:0] fr_angle;
		logic [15:0] fr_speed;
		logic signed [15:0] bl_angle;
		logic [15:0] bl_speed;
		logic signed [15:0] br_angle;
		logic [15:0] br_speed;
	} result_t;

	// corner sums handed from front to back
	typedef struct packed {
		logic stopped;
		logic signed [19:0] a;
		logic signed [19:0] b;
		logic signed [19:0] c;
		logic signed [19:0] d;
	} corners_t;

	// per wheel angles and raw speeds, order fl, fr, bl, br
	typedef struct packed {
		logic stopped;
		logic [3:0][15:0] angle;
		logic [3:0][17:0] speed;
	} wheels_t;

endpackage

>>> src/smk_front.sv
// front: deadband check, heading rotation and corner sums
module smk_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input smk_pkg::cmd_t cmd,
	input logic [12:0] wheel_base,
	input logic [12:0] track_width,
	input logic [14:0] deadband,
	output logic out_valid,
	output smk_pkg::corners_t out_item
);

	localparam int N = smk_pkg::ITERS;

	logic [N:0] vld_s;
	logic [N:0] stop_s;
	logic [N:0] fr_s;
	logic [N:0] flip_s;
	logic signed [15:0] xs_s [0:N];
	logic signed [15:0] ys_s [0:N];
	logic signed [15:0] om_s [0:N];
	logic signed [32:0] cx_s [0:N];
	logic signed [32:0] cy_s [0:N];
	logic signed [32:0] cz_s [0:N];

	logic [16:0] ax, ay, aw;
	logic flip_in;
	logic [15:0] h_in;

	function automatic logic [16:0] abs17(input logic signed [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? 17'(-e) : e;
	endfunction

	// deadband and quadrant fold of the heading
	always_comb begin
		ax = abs17(cmd.x_speed);
		ay = abs17(cmd.y_speed);
		aw = abs17(cmd.yaw_rate);
		flip_in = cmd.heading[15] ^ cmd.heading[14];
		h_in = {cmd.heading[15] ^ flip_in, cmd.heading[14:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// item capture and cordic seed
	always_ff @(posedge clk) begin
		stop_s[0] <= (ax < {2'b00, deadband}) && (ay < {2'b00, deadband}) &&
			(aw < {2'b00, deadband});
		fr_s[0] <= cmd.field_relative;
		flip_s[0] <= flip_in;
		xs_s[0] <= cmd.x_speed;
		ys_s[0] <= cmd.y_speed;
		om_s[0] <= cmd.yaw_rate;
		cx_s[0] <= smk_pkg::CORDIC_INV_GAIN;
		cy_s[0] <= '0;
		cz_s[0] <= {h_in[15], h_in, 16'h0000};
	end

	// rotation cordic, one iteration per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			stop_s[i+1] <= stop_s[i];
			fr_s[i+1] <= fr_s[i];
			flip_s[i+1] <= flip_s[i];
			xs_s[i+1] <= xs_s[i];
			ys_s[i+1] <= ys_s[i];
			om_s[i+1] <= om_s[i];
			if (!cz_s[i][32]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - $signed({1'b0, smk_pkg::ATAN_TAB[i]});
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + $signed({1'b0, smk_pkg::ATAN_TAB[i]});
			end
		end
	end

	// products stage
	logic signed [32:0] cs, sn;
	logic vld_s2, stop_s2, fr_s2;
	logic signed [15:0] xs_s2, ys_s2;
	logic signed [48:0] p_xc_s2, p_ys_s2, p_xs_s2, p_yc_s2;
	logic signed [29:0] ol_p_s2, ow_p_s2;

	always_comb begin
		cs = flip_s[N] ? -cx_s[N] : cx_s[N];
		sn = flip_s[N] ? -cy_s[N] : cy_s[N];
	end

	always_ff @(posedge clk) begin
		stop_s2 <= stop_s[N];
		fr_s2 <= fr_s[N];
		xs_s2 <= xs_s[N];
		ys_s2 <= ys_s[N];
		p_xc_s2 <= xs_s[N] * cs;
		p_ys_s2 <= ys_s[N] * sn;
		p_xs_s2 <= xs_s[N] * sn;
		p_yc_s2 <= ys_s[N] * cs;
		ol_p_s2 <= om_s[N] * $signed({1'b0, wheel_base});
		ow_p_s2 <= om_s[N] * $signed({1'b0, track_width});
	end

	// rounded sums stage
	logic signed [49:0] sum_f, sum_s;
	logic vld_s3, stop_s3;
	logic signed [17:0] fwd_s3, str_s3;
	logic signed [19:0] ol_s3, ow_s3;

	always_comb begin
		sum_f = 50'(p_xc_s2) + 50'(p_ys_s2) + 50'sd536870912;
		sum_s = 50'(p_yc_s2) - 50'(p_xs_s2) + 50'sd536870912;
	end

	always_ff @(posedge clk) begin
		stop_s3 <= stop_s2;
		fwd_s3 <= fr_s2 ? 18'(sum_f >>> 30) : 18'(xs_s2);
		str_s3 <= fr_s2 ? 18'(sum_s >>> 30) : 18'(ys_s2);
		ol_s3 <= 20'((ol_p_s2 + 30'sd1024) >>> 11);
		ow_s3 <= 20'((ow_p_s2 + 30'sd1024) >>> 11);
	end

	// corner sums stage
	logic signed [19:0] vx, vy;
	logic vld_s4;
	smk_pkg::corners_t item_s4;

	always_comb begin
		vx = -20'(str_s3);
		vy = 20'(fwd_s3);
	end

	always_ff @(posedge clk) begin
		item_s4.stopped <= stop_s3;
		item_s4.a <= vx - ol_s3;
		item_s4.b <= vx + ol_s3;
		item_s4.c <= vy - ow_s3;
		item_s4.d <= vy + ow_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s[N];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_item = item_s4;

endmodule

>>> src/smk_queue.sv
// short item queue between front and back
module smk_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input smk_pkg::corners_t push_item,
	output logic pop_valid,
	output smk_pkg::corners_t pop_item,
	output logic full
);

	localparam int D = smk_pkg::QUEUE_DEPTH;
	localparam int PW = smk_pkg::QPTR_W;

	smk_pkg::corners_t mem [0:D-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] count_q;
	logic pop;
	logic valid_q;
	smk_pkg::corners_t data_q;

	assign pop = (count_q != '0);
	assign full = (count_q == (PW+1)'(D));

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	// registered read, back side always drains
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= mem[rd_q];
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= pop;
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_valid = valid_q;
	assign pop_item = data_q;

endmodule

>>> src/smk_wheel.sv
// one wheel: vectoring cordic angle and rounded square root speed
module smk_wheel (
	input logic clk,
	input logic signed [19:0] py,
	input logic signed [19:0] px,
	output logic [15:0] angle,
	output logic [17:0] speed
);

	localparam int S = smk_pkg::WHEEL_STEPS;

	logic signed [33:0] px_w, py_w;
	logic neg;

	logic zero_s1;
	logic signed [33:0] x_s1, y_s1, z_s1;
	logic signed [40:0] sqy_s1, sqx_s1;

	logic [S:0] zero_s;
	logic signed [33:0] ax_s [0:S];
	logic signed [33:0] ay_s [0:S];
	logic signed [33:0] az_s [0:S];
	logic [37:0] n_s [0:S];
	logic [37:0] r_s [0:S];

	always_comb begin
		px_w = 34'(px);
		py_w = 34'(py);
		neg = px[19];
	end

	// half turn fold, operand scaling and squares
	always_ff @(posedge clk) begin
		zero_s1 <= (px == '0) && (py == '0);
		x_s1 <= (neg ? -px_w : px_w) <<< 12;
		y_s1 <= (neg ? -py_w : py_w) <<< 12;
		z_s1 <= neg ? 34'sh080000000 : 34'sd0;
		sqy_s1 <= py * py;
		sqx_s1 <= px * px;
	end

	// sum of squares
	always_ff @(posedge clk) begin
		zero_s[0] <= zero_s1;
		ax_s[0] <= x_s1;
		ay_s[0] <= y_s1;
		az_s[0] <= z_s1;
		n_s[0] <= 38'(sqy_s1 + sqx_s1);
		r_s[0] <= '0;
	end

	// shared step stages: angle iteration and root digit side by side
	for (genvar j = 0; j < S; j++) begin : g_step
		always_ff @(posedge clk) begin
			zero_s[j+1] <= zero_s[j];
		end

		if (j < smk_pkg::ITERS) begin : g_ang
			always_ff @(posedge clk) begin
				if (!ay_s[j][33]) begin
					ax_s[j+1] <= ax_s[j] + (ay_s[j] >>> j);
					ay_s[j+1] <= ay_s[j] - (ax_s[j] >>> j);
					az_s[j+1] <= az_s[j] + $signed({2'b00, smk_pkg::ATAN_TAB[j]});
				end else begin
					ax_s[j+1] <= ax_s[j] - (ay_s[j] >>> j);
					ay_s[j+1] <= ay_s[j] + (ax_s[j] >>> j);
					az_s[j+1] <= az_s[j] - $signed({2'b00, smk_pkg::ATAN_TAB[j]});
				end
			end
		end else begin : g_ang_pass
			always_ff @(posedge clk) begin
				ax_s[j+1] <= ax_s[j];
				ay_s[j+1] <= ay_s[j];
				az_s[j+1] <= az_s[j];
			end
		end

		if (j < smk_pkg::SQ_STEPS) begin : g_root
			localparam logic [37:0] BIT = 38'(1) << (36 - 2*j);
			always_ff @(posedge clk) begin
				if (n_s[j] >= r_s[j] + BIT) begin
					n_s[j+1] <= n_s[j] - (r_s[j] + BIT);
					r_s[j+1] <= (r_s[j] >> 1) + BIT;
				end else begin
					n_s[j+1] <= n_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
			end
		end else begin : g_root_pass
			always_ff @(posedge clk) begin
				n_s[j+1] <= n_s[j];
				r_s[j+1] <= r_s[j];
			end
		end
	end

	// negate and round angle, round root to nearest
	logic signed [33:0] zr;

	assign zr = -az_s[S] + 34'sd32768;

	always_ff @(posedge clk) begin
		angle <= zero_s[S] ? 16'h0000 : zr[31:16];
		speed <= 18'(r_s[S]) + {17'd0, (n_s[S] > r_s[S])};
	end

endmodule

>>> src/smk_back.sv
// back: four wheel units, largest speed, scaling divide and result register
module smk_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input smk_pkg::corners_t in_item,
	input logic [14:0] max_speed,
	output logic out_valid,
	output smk_pkg::result_t out_item
);

	localparam int L = smk_pkg::WHEEL_LAT;
	localparam int D = smk_pkg::DIV_STEPS;

	logic [3:0][15:0] ang;
	logic [3:0][17:0] spd;

	// wheel pairs: fl (b,d), fr (b,c), bl (a,d), br (a,c)
	smk_wheel u_fl (.clk(clk), .py(in_item.b), .px(in_item.d), .angle(ang[0]),
		.speed(spd[0]));
	smk_wheel u_fr (.clk(clk), .py(in_item.b), .px(in_item.c), .angle(ang[1]),
		.speed(spd[1]));
	smk_wheel u_bl (.clk(clk), .py(in_item.a), .px(in_item.d), .angle(ang[2]),
		.speed(spd[2]));
	smk_wheel u_br (.clk(clk), .py(in_item.a), .px(in_item.c), .angle(ang[3]),
		.speed(spd[3]));

	// valid and stop flags alongside the wheel units
	logic [L-1:0] vd_q;
	logic [L-1:0] sd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q <= '0;
		end else begin
			vd_q <= {vd_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		sd_q <= {sd_q[L-2:0], in_item.stopped};
	end

	// max tree, first level
	smk_pkg::wheels_t w_s2, w_s3, w_s4;
	logic [17:0] m01_s2, m23_s2, mx_s3, mx_s4;
	logic scale_s3, scale_s4;
	logic [3:0][32:0] prod_s4;

	always_ff @(posedge clk) begin
		w_s2.stopped <= sd_q[L-1];
		w_s2.angle <= ang;
		w_s2.speed <= spd;
		m01_s2 <= (spd[0] > spd[1]) ? spd[0] : spd[1];
		m23_s2 <= (spd[2] > spd[3]) ? spd[2] : spd[3];
	end

	// max tree, second level and limit compare
	always_ff @(posedge clk) begin
		w_s3 <= w_s2;
		mx_s3 <= (m01_s2 > m23_s2) ? m01_s2 : m23_s2;
		scale_s3 <= ((m01_s2 > m23_s2) ? m01_s2 : m23_s2) > {3'b000, max_speed};
	end

	// speed times limit
	always_ff @(posedge clk) begin
		w_s4 <= w_s3;
		mx_s4 <= mx_s3;
		scale_s4 <= scale_s3;
		for (int k = 0; k < 4; k++) begin
			prod_s4[k] <= w_s3.speed[k] * max_speed;
		end
	end

	// divider pipeline, index 0 holds the rounded numerator
	smk_pkg::wheels_t w_d [0:D];
	logic [3:0][33:0] rem_d [0:D];
	logic [3:0][15:0] quo_d [0:D];
	logic [17:0] mx_d [0:D];
	logic [D:0] scale_d;

	always_ff @(posedge clk) begin
		w_d[0] <= w_s4;
		mx_d[0] <= mx_s4;
		scale_d[0] <= scale_s4;
		quo_d[0] <= '0;
		for (int k = 0; k < 4; k++) begin
			rem_d[0][k] <= 34'(prod_s4[k]) + 34'(mx_s4 >> 1);
		end
	end

	for (genvar j = 0; j < D; j++) begin : g_div
		localparam int B = D - 1 - j;
		logic [33:0] dv;
		assign dv = 34'(mx_d[j]) << B;
		always_ff @(posedge clk) begin
			w_d[j+1] <= w_d[j];
			mx_d[j+1] <= mx_d[j];
			scale_d[j+1] <= scale_d[j];
			for (int k = 0; k < 4; k++) begin
				if (rem_d[j][k] >= dv) begin
					rem_d[j+1][k] <= rem_d[j][k] - dv;
					quo_d[j+1][k] <= quo_d[j][k] | (16'd1 << B);
				end else begin
					rem_d[j+1][k] <= rem_d[j][k];
					quo_d[j+1][k] <= quo_d[j][k];
				end
			end
		end
	end

	// valid flags through tree, multiply and divider
	logic [D+4:0] vq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_q <= '0;
		end else begin
			vq_q <= {vq_q[D+3:0], vd_q[L-1]};
		end
	end

	// result select and register
	logic [3:0][15:0] fin;
	smk_pkg::result_t res_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (w_d[D].stopped) begin
				fin[k] = '0;
			end else if (scale_d[D]) begin
				fin[k] = quo_d[D][k];
			end else begin
				fin[k] = w_d[D].speed[k][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q.stopped <= w_d[D].stopped;
		res_q.fl_angle <= w_d[D].stopped ? 16'sd0 : $signed(w_d[D].angle[0]);
		res_q.fr_angle <= w_d[D].stopped ? 16'sd0 : $signed(w_d[D].angle[1]);
		res_q.bl_angle <= w_d[D].stopped ? 16'sd0 : $signed(w_d[D].angle[2]);
		res_q.br_angle <= w_d[D].stopped ? 16'sd0 : $signed(w_d[D].angle[3]);
		res_q.fl_speed <= fin[0];
		res_q.fr_speed <= fin[1];
		res_q.bl_speed <= fin[2];
		res_q.br_speed <= fin[3];
	end

	assign out_valid = vq_q[D+4];
	assign out_item = res_q;

endmodule

>>> src/swerve_module_kinematics_unit.sv
// Swerve drive inverse kinematics: one chassis command in, four wheel angles
// and speeds out. A command is taken on any cycle with start high and busy low,
// one per clock; busy stays low in normal use since nothing downstream can
// stall. Each command yields exactly one result, shown for one cycle with done
// high, in command order. Each command passes through the heading rotation cordic
// (one iteration per stage), the per-wheel angle cordic and 19-step square root
// pipeline, and the 16-stage speed scaling divider. The result receiver must take
// every item on the done cycle. Registers are to be written over the APB port
// only while idle; the block itself does not enforce this.
module swerve_module_kinematics_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input smk_pkg::cmd_t cmd,
	output logic done,
	output smk_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [12:0] wheel_base_q;
	logic [12:0] track_width_q;
	logic [14:0] max_speed_q;
	logic [14:0] deadband_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q <= smk_pkg::WHEEL_BASE_RST;
			track_width_q <= smk_pkg::TRACK_WIDTH_RST;
			max_speed_q <= smk_pkg::MAX_SPEED_RST;
			deadband_q <= smk_pkg::DEADBAND_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				smk_pkg::REG_WHEEL_BASE: wheel_base_q <= pwdata[12:0];
				smk_pkg::REG_TRACK_WIDTH: track_width_q <= pwdata[12:0];
				smk_pkg::REG_MAX_SPEED: max_speed_q <= pwdata[14:0];
				smk_pkg::REG_DEADBAND: deadband_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			smk_pkg::REG_WHEEL_BASE: prdata = {19'd0, wheel_base_q};
			smk_pkg::REG_TRACK_WIDTH: prdata = {19'd0, track_width_q};
			smk_pkg::REG_MAX_SPEED: prdata = {17'd0, max_speed_q};
			smk_pkg::REG_DEADBAND: prdata = {17'd0, deadband_q};
			default: prdata = '0;
		endcase
	end

	logic accept;
	logic f_valid;
	smk_pkg::corners_t f_item;
	logic q_valid;
	smk_pkg::corners_t q_item;
	logic q_full;

	assign accept = start & ~busy;
	assign busy = q_full;

	// front classifies and forms corner sums
	smk_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.cmd(cmd),
		.wheel_base(wheel_base_q),
		.track_width(track_width_q),
		.deadband(deadband_q),
		.out_valid(f_valid),
		.out_item(f_item)
	);

	// decoupling queue
	smk_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.push_item(f_item),
		.pop_valid(q_valid),
		.pop_item(q_item),
		.full(q_full)
	);

	// back computes wheel angles and speeds
	smk_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_item(q_item),
		.max_speed(max_speed_q),
		.out_valid(done),
		.out_item(result)
	);

endmodule
